// File: rtl/core/dqc_pkg.sv
`default_nettype none

package dqc_pkg;

    localparam logic [2:0] ACT_PUSH_L = 3'd0;
    localparam logic [2:0] ACT_PUSH_R = 3'd1;
    localparam logic [2:0] ACT_POP_L  = 3'd2;
    localparam logic [2:0] ACT_POP_R  = 3'd3;
    localparam logic [2:0] ACT_CUR_L  = 3'd4;
    localparam logic [2:0] ACT_CUR_R  = 3'd5;
    localparam logic [2:0] ACT_SET    = 3'd6;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [31:0] value;
    } req_word_t;

    typedef struct packed {
        logic signed [31:0] popped_value;
        logic signed [31:0] left_value;
        logic signed [31:0] right_value;
        logic signed [31:0] cursor_value;
        logic [4:0]         count;
        logic               moved;
        logic [1:0]         status;
    } rsp_word_t;

    typedef enum logic [1:0] {
        RSEL_POP    = 2'd0,
        RSEL_LEFT   = 2'd1,
        RSEL_RIGHT  = 2'd2,
        RSEL_CURSOR = 2'd3
    } rsel_t;

    typedef struct packed {
        logic  latch;
        logic  exec;
        logic  rd_en;
        rsel_t rsel;
        logic  cap_pop;
        logic  cap_left;
        logic  cap_right;
        logic  load_out;
    } dqc_cmd_t;

endpackage

`default_nettype wire

// File: rtl/core/dqc_ctrl.sv
`default_nettype none

module dqc_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output dqc_pkg::dqc_cmd_t      cmd
);
    import dqc_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EXEC = 6'b000010,
        S_RD_L = 6'b000100,
        S_RD_R = 6'b001000,
        S_RD_C = 6'b010000,
        S_CAP  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.rsel      = RSEL_POP;
        req_ready     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                cmd.latch = req_valid;
                if (req_valid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                cmd.rd_en  = 1'b1;
                cmd.rsel   = RSEL_POP;
                state_next = S_RD_L;
            end
            S_RD_L:
            begin
                cmd.cap_pop = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.rsel    = RSEL_LEFT;
                state_next  = S_RD_R;
            end
            S_RD_R:
            begin
                cmd.cap_left = 1'b1;
                cmd.rd_en    = 1'b1;
                cmd.rsel     = RSEL_RIGHT;
                state_next   = S_RD_C;
            end
            S_RD_C:
            begin
                cmd.cap_right = 1'b1;
                cmd.rd_en     = 1'b1;
                cmd.rsel      = RSEL_CURSOR;
                state_next    = S_CAP;
            end
            S_CAP:
            begin
                // hold until the output register is free
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

`default_nettype wire

// File: rtl/core/dqc_dp.sv
`default_nettype none

module dqc_dp #(
    parameter int DEPTH = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire dqc_pkg::dqc_cmd_t cmd,
    input  wire dqc_pkg::req_word_t req,
    output dqc_pkg::rsp_word_t     rsp
);
    import dqc_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [IW-1:0] LAST  = IW'(DEPTH - 1);
    localparam logic [CW-1:0] FULLC = CW'(DEPTH);

    function automatic logic [IW-1:0] ring_inc(input logic [IW-1:0] i);
        return (i == LAST) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IW-1:0] ring_dec(input logic [IW-1:0] i);
        return (i == '0) ? LAST : i - 1'b1;
    endfunction

    logic [31:0]   word_store_reg [DEPTH];
    logic [31:0]   rdata_reg;

    logic [2:0]    action_reg;
    logic [31:0]   value_reg;

    logic [IW-1:0] left_reg, left_next;
    logic [IW-1:0] right_reg, right_next;
    logic [IW-1:0] cursor_reg, cursor_next;
    logic [CW-1:0] count_reg, count_next;

    logic [1:0]    status_reg, status_next;
    logic          moved_reg, moved_next;
    logic          pop_ok_reg, pop_ok_next;
    logic [31:0]   popped_reg, left_val_reg, right_val_reg;
    rsp_word_t     rsp_reg;

    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [IW-1:0] rd_addr;
    logic          empty, full;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == FULLC);

    always_comb
    begin
        left_next   = left_reg;
        right_next  = right_reg;
        cursor_next = cursor_reg;
        count_next  = count_reg;
        status_next = ST_OK;
        moved_next  = 1'b0;
        pop_ok_next = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = left_reg;
        case (action_reg)
            ACT_PUSH_L, ACT_PUSH_R:
            begin
                if (full)
                    status_next = ST_FULL;
                else if (empty)
                begin
                    right_next  = left_reg;
                    cursor_next = left_reg;
                    wr_en       = 1'b1;
                    wr_addr     = left_reg;
                    count_next  = CW'(1);
                end
                else if (action_reg == ACT_PUSH_L)
                begin
                    left_next  = ring_dec(left_reg);
                    wr_en      = 1'b1;
                    wr_addr    = ring_dec(left_reg);
                    count_next = count_reg + 1'b1;
                end
                else
                begin
                    right_next = ring_inc(right_reg);
                    wr_en      = 1'b1;
                    wr_addr    = ring_inc(right_reg);
                    count_next = count_reg + 1'b1;
                end
            end
            ACT_POP_L:
            begin
                if (empty)
                    status_next = ST_EMPTY;
                else
                begin
                    pop_ok_next = 1'b1;
                    if (count_reg == CW'(1))
                    begin
                        right_next  = left_reg;
                        cursor_next = left_reg;
                    end
                    else
                    begin
                        if (cursor_reg == left_reg)
                            cursor_next = ring_inc(cursor_reg);
                        left_next = ring_inc(left_reg);
                    end
                    count_next = count_reg - 1'b1;
                end
            end
            ACT_POP_R:
            begin
                if (empty)
                    status_next = ST_EMPTY;
                else
                begin
                    pop_ok_next = 1'b1;
                    if (count_reg == CW'(1))
                    begin
                        left_next   = right_reg;
                        cursor_next = right_reg;
                    end
                    else
                    begin
                        if (cursor_reg == right_reg)
                            cursor_next = ring_dec(cursor_reg);
                        right_next = ring_dec(right_reg);
                    end
                    count_next = count_reg - 1'b1;
                end
            end
            ACT_CUR_L:
            begin
                if (empty)
                    status_next = ST_EMPTY;
                else if (cursor_reg != left_reg)
                begin
                    cursor_next = ring_dec(cursor_reg);
                    moved_next  = 1'b1;
                end
            end
            ACT_CUR_R:
            begin
                if (empty)
                    status_next = ST_EMPTY;
                else if (cursor_reg != right_reg)
                begin
                    cursor_next = ring_inc(cursor_reg);
                    moved_next  = 1'b1;
                end
            end
            ACT_SET:
            begin
                if (empty)
                    status_next = ST_EMPTY;
                else
                begin
                    wr_en   = 1'b1;
                    wr_addr = cursor_reg;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        case (cmd.rsel)
            RSEL_POP:    rd_addr = (action_reg == ACT_POP_L) ? left_reg : right_reg;
            RSEL_LEFT:   rd_addr = left_reg;
            RSEL_RIGHT:  rd_addr = right_reg;
            RSEL_CURSOR: rd_addr = cursor_reg;
            default:     rd_addr = left_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && wr_en)
            word_store_reg[wr_addr] <= value_reg;
        if (cmd.rd_en)
            rdata_reg <= word_store_reg[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= '0;
            right_reg  <= '0;
            cursor_reg <= '0;
            count_reg  <= '0;
        end
        else if (cmd.exec)
        begin
            left_reg   <= left_next;
            right_reg  <= right_next;
            cursor_reg <= cursor_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            action_reg <= req.action;
            value_reg  <= req.value;
        end
        if (cmd.exec)
        begin
            status_reg <= status_next;
            moved_reg  <= moved_next;
            pop_ok_reg <= pop_ok_next;
        end
        if (cmd.cap_pop)
            popped_reg <= pop_ok_reg ? rdata_reg : '0;
        if (cmd.cap_left)
            left_val_reg <= rdata_reg;
        if (cmd.cap_right)
            right_val_reg <= rdata_reg;
        if (cmd.load_out)
        begin
            rsp_reg.popped_value <= popped_reg;
            rsp_reg.left_value   <= empty ? '0 : left_val_reg;
            rsp_reg.right_value  <= empty ? '0 : right_val_reg;
            rsp_reg.cursor_value <= empty ? '0 : rdata_reg;
            rsp_reg.count        <= 5'(count_reg);
            rsp_reg.moved        <= moved_reg;
            rsp_reg.status       <= status_reg;
        end
    end

    assign rsp = rsp_reg;

endmodule

`default_nettype wire

// File: rtl/core/deque_with_cursor_unit.sv
`default_nettype none

// Double-ended queue of signed 32-bit words with a movable cursor, stored in a
// ring of DEPTH entries. Each request word carries one action (push left/right,
// pop left/right, cursor left/right, set cursor word) and yields one response
// word with the popped word, both end words, the cursor word, the count, a
// moved flag and a status. An accepted request passes the execute, left-read,
// right-read, cursor-read and capture states, and no new request is taken until
// its response is loaded into the output register once that is free. The word
// store's single read port is used once for the popped word and once each for
// the left, right and cursor words. A finished response waits in the output
// register while the next request is taken. Pushes into a full queue and pops,
// cursor moves or sets on an empty queue report a status and change nothing.
module deque_with_cursor_unit #(
    parameter int DEPTH = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire dqc_pkg::req_word_t req,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output dqc_pkg::rsp_word_t      rsp
);
    import dqc_pkg::*;

    dqc_cmd_t cmd;

    dqc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd)
    );

    dqc_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire

// File: rtl/core/dqc_check.sv
`default_nettype none

module dqc_check #(
    parameter int DEPTH = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               rsp_valid,
    input  wire logic               rsp_ready,
    input  wire dqc_pkg::rsp_word_t rsp
);
    import dqc_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_FULL |-> rsp.count == 5'(DEPTH))
        else $error("full status without full count");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.count == 5'd0 && rsp.status == ST_EMPTY |->
            rsp.left_value == 0 && rsp.right_value == 0 && rsp.cursor_value == 0)
        else $error("empty queue reports nonzero words");

    a_err_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != ST_OK |-> rsp.popped_value == 0 && !rsp.moved)
        else $error("failed action popped or moved");

endmodule

bind deque_with_cursor_unit dqc_check #(.DEPTH(DEPTH)) u_dqc_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

`default_nettype wire
